@@ hdl/mavg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types, sizes and helpers for the moving average block: request and
// result payloads, controller commands and status, and the window size clamp.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Largest window the sample ring can hold.
  localparam int MAX_WINDOW = 256;

  // Width of the window size register.
  localparam int WIN_W  = 9;
  // Ring index, and counters that must be able to hold MAX_WINDOW itself.
  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  // Running sum of up to MAX_WINDOW signed 32-bit samples.
  localparam int SUM_W  = 32 + IDX_W;
  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);
  // One ring entry: present flag over the 32-bit sample.
  localparam int ENTRY_W = 33;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               sample_valid;
    logic               last_of_series;
  } in_t;

  typedef struct packed {
    logic signed [31:0] average;
    logic               average_valid;
    logic               last_out;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the request and read the ring slot
    logic update;     // evict, store the sample, update sum and counts
    logic div_start;  // load the divider from the running sum
    logic div_step;   // one quotient bit
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;   // the step under way is the final one
    logic out_busy;   // output register cannot take a new result this cycle
  } sts_t;

  // Effective window: zero counts as one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
    logic [CNT_W-1:0] w;
    if (ws == '0) begin
      w = CNT_W'(1);
    end else if (32'(ws) > 32'(MAX_WINDOW)) begin
      w = CNT_W'(MAX_WINDOW);
    end else begin
      w = CNT_W'(ws);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mavg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/mavg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_ctrl
// Controller: sequences one request through capture, ring update, divider
// load, the bit-serial division and the hand-over to the output register.
// ----------------------------------------------------------------------------
module mavg_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  mavg_pkg::sts_t sts,
  output mavg_pkg::cmd_t cmd
);

  import mavg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_LOAD,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t state;

  // A new request is taken only between items, and never during reset.
  assign in_ready = (state == S_IDLE) && !rst;

  // Commands decode from the current state.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.capture   = in_valid;
      S_UPDATE: cmd.update    = 1'b1;
      S_LOAD:   cmd.div_start = 1'b1;
      S_DIVIDE: cmd.div_step  = 1'b1;
      S_DONE:   cmd.load_out  = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: state <= S_LOAD;
        S_LOAD:   state <= S_DIVIDE;
        S_DIVIDE: begin
          if (sts.div_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/mavg_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_datapath
// Datapath: window size register, sample ring, running sum and counters,
// a restoring divider one bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module mavg_datapath (
  input  wire             clk,
  input  wire             rst,
  input  mavg_pkg::cmd_t  cmd,
  output mavg_pkg::sts_t  sts,
  input  mavg_pkg::in_t   in_data,
  input  wire             cfg_we,
  input  wire  [8:0]      cfg_wdata,
  output mavg_pkg::out_t  out_data,
  output logic            out_valid,
  input  wire             out_ready
);

  import mavg_pkg::*;

  logic [WIN_W-1:0]        window_size;
  logic [CNT_W-1:0]        win;
  in_t                     sample;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        cap_idx;
  logic [IDX_W-1:0]        write_index;
  logic [CNT_W-1:0]        fill_count;
  logic [CNT_W-1:0]        missing_count;
  logic signed [SUM_W-1:0] running_sum;
  logic                    avg_ok;

  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic                    old_ok;
  logic                    evict;
  logic signed [SUM_W-1:0] sub_term;
  logic signed [SUM_W-1:0] add_term;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        fill_next;
  logic [CNT_W-1:0]        missing_next;
  logic [CNT_W-1:0]        idx_inc;
  logic [IDX_W-1:0]        write_index_next;

  logic [SUM_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic [STEP_W-1:0]       step;
  logic                    neg;
  logic [CNT_W:0]          trial;
  logic                    trial_ge;

  assign win = eff_window(window_size);

  // Slot of this sample: the write position wraps if the window shrank.
  assign cap_idx = (CNT_W'(write_index) >= win) ? '0 : write_index;

  // Missing samples are stored as zero with the present flag clear.
  assign ram_wdata = {sample.sample_valid,
                      sample.sample_valid ? sample.sample_value : 32'sd0};

  mavg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (cap_idx),
    .rdata (ram_rdata)
  );

  // Ring update: evict the oldest sample once the window is full.
  always_comb begin
    old_ok   = ram_rdata[ENTRY_W-1];
    evict    = (fill_count >= win);
    sub_term = (evict && old_ok) ? SUM_W'($signed(ram_rdata[31:0])) : '0;
    add_term = sample.sample_valid ? SUM_W'(sample.sample_value) : '0;
    sum_next = running_sum - sub_term + add_term;
    fill_next = evict ? fill_count : fill_count + CNT_W'(1);
    missing_next = missing_count;
    if (evict && !old_ok && (missing_count != '0)) begin
      missing_next = missing_count - CNT_W'(1);
    end
    if (!sample.sample_valid) begin
      missing_next = missing_next + CNT_W'(1);
    end
    idx_inc = CNT_W'(idx) + CNT_W'(1);
    write_index_next = (idx_inc >= win) ? '0 : IDX_W'(idx_inc);
  end

  // Request capture; payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= in_data;
      idx    <= cap_idx;
    end
    if (cmd.update) begin
      avg_ok <= (missing_next < fill_next);
    end
  end

  // Window size register and series state. A register write or the end of a
  // series starts a new series.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WIN_W'(1);
      running_sum   <= '0;
      missing_count <= '0;
      fill_count    <= '0;
      write_index   <= '0;
    end else if (cfg_we) begin
      window_size   <= cfg_wdata;
      running_sum   <= '0;
      missing_count <= '0;
      fill_count    <= '0;
      write_index   <= '0;
    end else if (cmd.load_out && sample.last_of_series) begin
      running_sum   <= '0;
      missing_count <= '0;
      fill_count    <= '0;
      write_index   <= '0;
    end else if (cmd.update) begin
      running_sum   <= sum_next;
      missing_count <= missing_next;
      fill_count    <= fill_next;
      write_index   <= write_index_next;
    end
  end

  // Restoring divider step: shift in the next dividend bit, subtract if it fits.
  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, win});

  // Divider works on the magnitude; the sign is applied at the end.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg  <= running_sum[SUM_W-1];
      quo  <= running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[SUM_W-2:0], trial_ge};
      rem  <= trial_ge ? CNT_W'(trial - {1'b0, win}) : CNT_W'(trial);
      step <= step + STEP_W'(1);
    end
  end

  assign sts.div_last = (step == STEP_W'(DIV_STEPS - 1));
  assign sts.out_busy = out_valid && !out_ready;

  // Output register: holds the result until the far side takes it.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.average       <= avg_ok ? (neg ? -$signed(quo[31:0]) : $signed(quo[31:0]))
                                       : 32'sd0;
      out_data.average_valid <= avg_ok;
      out_data.last_out      <= sample.last_of_series;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/moving_average_with_gaps.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_with_gaps
// Boxcar moving average over signed Q16.16 samples that may be missing.
// A request passes through capture with the ring read, the ring update, the
//   divider load, the bit-serial division over the 40-bit running sum (one
//   quotient bit per cycle) and the hand-over to the output register. The
//   next request is taken only after that hand-over, so requests are not
//   overlapped, and a receiver that stalls holds the block.
// Reset clears the series state and sets the window size to one; the ring
//   itself is not cleared, as only slots written in the current series are used.
// ----------------------------------------------------------------------------
module moving_average_with_gaps (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  mavg_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output mavg_pkg::out_t  out_data,
  input  wire             cfg_we,
  input  wire  [8:0]      cfg_wdata
);

  import mavg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mavg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // At most one command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A captured request is always followed by the ring update.
  a_capture_update: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.update)
    else $error("capture not followed by ring update");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("output register overwritten");

  // Loading a result raises the output valid in the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire

@@ tb/sv/mavg_checker.sv @@
// ----------------------------------------------------------------------------
// mavg_checker
// Watches the request, result and window size ports of the moving average
// block. It keeps its own copy of the sample ring, running sum and counters,
// predicts one result per accepted request, and compares each accepted
// result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mavg_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  mavg_pkg::in_t                in_data,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  mavg_pkg::out_t               out_data,
  input  wire                          cfg_we,
  input  wire  [mavg_pkg::WIN_W-1:0]   cfg_wdata,
  output int                           failures,
  output int                           pending
);

  import mavg_pkg::*;

  // Predicted copy of the register and the series state.
  logic [WIN_W-1:0]        win_setting;
  logic signed [31:0]      ring_value [MAX_WINDOW];
  logic                    ring_present [MAX_WINDOW];
  logic signed [SUM_W-1:0] window_sum;
  logic [CNT_W-1:0]        gap_count;
  logic [CNT_W-1:0]        fill_level;
  logic [IDX_W-1:0]        head_slot;

  out_t pending_averages[$];
  int   mismatches = 0;

  initial begin
    failures = 0;
    pending  = 0;
  end

  // A zero setting averages one sample; anything past the ring saturates.
  function automatic logic [CNT_W-1:0] clamp_window(input logic [WIN_W-1:0] ws);
    if (ws == '0) begin
      return CNT_W'(1);
    end else if (int'(ws) > MAX_WINDOW) begin
      return CNT_W'(MAX_WINDOW);
    end
    return CNT_W'(ws);
  endfunction

  function automatic void clear_series();
    window_sum = '0;
    gap_count  = '0;
    fill_level = '0;
    head_slot  = '0;
  endfunction

  // Advances the predicted state by one sample and returns its average.
  function automatic out_t next_average(input in_t req);
    logic [CNT_W-1:0]        w;
    logic [IDX_W-1:0]        slot;
    logic signed [SUM_W-1:0] evicted;
    logic signed [SUM_W-1:0] incoming;
    logic signed [SUM_W-1:0] divisor;
    logic signed [SUM_W-1:0] quotient;
    out_t                    res;
    w = clamp_window(win_setting);
    if (CNT_W'(head_slot) >= w) begin
      slot = '0;
    end else begin
      slot = head_slot;
    end

    // Once the window is full, the oldest sample leaves at the write slot.
    if (fill_level >= w) begin
      if (ring_present[slot]) begin
        evicted    = SUM_W'(ring_value[slot]);
        window_sum = window_sum - evicted;
      end else if (gap_count != '0) begin
        gap_count = gap_count - CNT_W'(1);
      end
    end else begin
      fill_level = fill_level + CNT_W'(1);
    end

    ring_present[slot] = req.sample_valid;
    ring_value[slot]   = req.sample_valid ? req.sample_value : '0;
    if (req.sample_valid) begin
      incoming   = SUM_W'(req.sample_value);
      window_sum = window_sum + incoming;
    end else begin
      gap_count = gap_count + CNT_W'(1);
    end

    if (CNT_W'(slot) + CNT_W'(1) >= w) begin
      head_slot = '0;
    end else begin
      head_slot = slot + IDX_W'(1);
    end

    // The divisor is the full window even during warm-up.
    res.average_valid = gap_count < fill_level;
    divisor           = SUM_W'(w);
    quotient          = window_sum / divisor;
    res.average       = res.average_valid ? quotient[31:0] : '0;
    res.last_out      = req.last_of_series;

    if (req.last_of_series) begin
      clear_series();
    end
    return res;
  endfunction

  // Results are retired before the request of the same edge is predicted.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      win_setting = WIN_W'(1);
      clear_series();
      pending_averages.delete();
    end else begin
      if (cfg_we) begin
        win_setting = cfg_wdata;
        clear_series();
      end
      if (out_valid && out_ready) begin
        if (pending_averages.size() == 0) begin
          $display("%0t: result with no request outstanding: average %0d valid %0b last %0b",
                   $time, out_data.average, out_data.average_valid, out_data.last_out);
          mismatches = mismatches + 1;
        end else begin
          want = pending_averages.pop_front();
          if (out_data.average !== want.average) begin
            $display("%0t: average expected %0d got %0d",
                     $time, want.average, out_data.average);
            mismatches = mismatches + 1;
          end
          if (out_data.average_valid !== want.average_valid) begin
            $display("%0t: average_valid expected %0b got %0b",
                     $time, want.average_valid, out_data.average_valid);
            mismatches = mismatches + 1;
          end
          if (out_data.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b got %0b",
                     $time, want.last_out, out_data.last_out);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_averages.insert(pending_averages.size(), next_average(in_data));
      end
    end
    pending  <= pending_averages.size();
    failures <= mismatches;
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the moving average block with a short directed sequence and then
// random series over several window sizes, the extremes among them, with
// bursty requests and a stalling receiver. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mavg_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 8;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_HALF,
    DRAIN_SPARSE,
    DRAIN_MOSTLY
  } drain_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_wdata = '0;

  int failures;
  int pending;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit gapless = 1'b0;

  always #6 clk = ~clk;

  moving_average_with_gaps u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mavg_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  // Ends the run when no request and no result has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[moving_average_with_gaps] ERROR");
      $finish;
    end
  end

  // The receiver switches between four random stall patterns, holding each for a random span.
  initial begin
    drain_mode_t drain;
    int          span;
    forever begin
      drain = drain_mode_t'($urandom_range(0, 3));
      span  = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (drain)
          DRAIN_FREE:   out_ready <= 1'b1;
          DRAIN_HALF:   out_ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
          default:      out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Presents one request at a falling edge and holds it until taken. When a
  // burst runs out and gaps are enabled, valid drops for a random gap.
  task automatic send_sample(input logic [31:0] value, input logic present,
                             input logic last);
    in_t req;
    req.sample_value   = value;
    req.sample_valid   = present;
    req.last_of_series = last;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    if (!gapless && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end else if (burst_left != 0) begin
      burst_left = burst_left - 1;
    end
  endtask

  // The window register is only written once every result is back.
  task automatic write_window(input logic [WIN_W-1:0] setting);
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed series of random length and density, closed by a last mark,
  // with the odd early last mark as noise. Extreme series push the running
  // sum towards its limits with long runs of one full-scale value.
  task automatic run_series(input int count, input int span_cap, input bit extreme);
    int          done;
    int          span;
    int          density;
    int          k;
    bit          negative;
    logic [31:0] value;
    logic        present;
    logic        last;
    done = 0;
    while (done < count) begin
      if (extreme) begin
        span    = $urandom_range(260, 300);
        density = ($urandom_range(0, 1) != 0) ? 100 : 95;
      end else begin
        span = $urandom_range(1, span_cap);
        case ($urandom_range(0, 4))
          0:       density = 100;
          1:       density = 85;
          2:       density = 50;
          3:       density = 15;
          default: density = 0;
        endcase
      end
      negative = $urandom_range(0, 1);
      for (k = 0; k < span && done < count; k++) begin
        present = ($urandom_range(1, 100) <= density);
        if (extreme && $urandom_range(0, 9) != 0) begin
          value = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          value = pick_value();
        end
        last = (k == span - 1) || ($urandom_range(0, 99) == 0);
        send_sample(value, present, last);
        done++;
      end
    end
  endtask

  // Main stimulus: directed checks first, then random phases.
  initial begin
    int               p;
    logic [WIN_W-1:0] phase_window [PHASES];
    int               phase_count  [PHASES];
    int               phase_span   [PHASES];
    phase_window = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd256, 9'd511, 9'd0, 9'd0};
    phase_count  = '{60, 60, 60, 90, 290, 60, 80, 40};
    phase_span   = '{6, 6, 10, 20, 0, 80, 50, 40};
    phase_window[6] = WIN_W'($urandom_range(3, 24));
    phase_window[7] = WIN_W'($urandom_range(257, 510));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Window of one straight out of reset, including a missing sample.
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h1234_5678, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b1);

    // Window of three: full-scale samples, a window of only missing
    // samples, truncation toward zero for negative sums, and a series that
    // opens with a missing sample and ends at once.
    write_window(9'd3);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b1, 1'b0);
    send_sample(32'h0000_0005, 1'b1, 1'b1);
    send_sample(32'h0000_007B, 1'b0, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b1);

    // Random phases; every other phase runs without request gaps.
    for (p = 0; p < PHASES; p++) begin
      write_window(phase_window[p]);
      gapless = p[0];
      run_series(phase_count[p], phase_span[p], phase_window[p] == 9'd256);
    end

    in_valid <= 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("[moving_average_with_gaps] OK");
    end else begin
      $display("[moving_average_with_gaps] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mavg_pkg.sv
hdl/mavg_ram.sv
hdl/mavg_ctrl.sv
hdl/mavg_datapath.sv
hdl/moving_average_with_gaps.sv
tb/sv/mavg_checker.sv
tb/sv/testbench.sv
